// ===== rtl/core/max_subarray_tracker_defines.svh =====
// Assertion macros for the max subarray tracker.
`ifndef MAX_SUBARRAY_TRACKER_DEFINES_SVH
`define MAX_SUBARRAY_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define MST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MST_ASSERT(lbl, clk, rstn, prop, msg)
`define MST_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/mst_pkg.sv =====
// Constants and types shared by the max subarray tracker.
`timescale 1ns / 1ps
`default_nettype none
package mst_pkg;
  localparam int MaxLen     = 1024;
  localparam int SampleBits = 16;
  localparam int SampleW    = 16;
  localparam int SumW       = 25;
  localparam int FirstW     = 10;
  localparam int LenW       = 11;
  localparam int CntW       = $clog2(MaxLen + 1);
  localparam int ExtW       = ((SumW > SampleBits) ? SumW : SampleBits) + 2;
  localparam logic [SumW-1:0] SumSat = {SumW{1'b1}};

  typedef struct packed {
    logic [SumW-1:0]   best_sum;
    logic [FirstW-1:0] best_start;
    logic [LenW-1:0]   best_length;
    logic [SumW-1:0]   suffix_sum;
    logic [LenW-1:0]   suffix_length;
    logic              overrun;
    logic              final_res;
  } mst_result_t;
endpackage
`default_nettype wire

// ===== rtl/core/mst_core.sv =====
// Kadane scan state and its combinational update per request.
`timescale 1ns / 1ps
`default_nettype none
`include "max_subarray_tracker_defines.svh"
module mst_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         step_i,
  input  wire logic [mst_pkg::SampleW-1:0]  sample_i,
  input  wire logic                         last_i,
  output mst_pkg::mst_result_t              result_o
);
  localparam int ExtW = mst_pkg::ExtW;
  localparam int SumW = mst_pkg::SumW;
  localparam int CntW = mst_pkg::CntW;
  localparam int SmpB = mst_pkg::SampleBits;

  logic [SumW-1:0] suffix_total_q, suffix_total_d;
  logic [CntW-1:0] suffix_count_q, suffix_count_d;
  logic [SumW-1:0] best_total_q, best_total_d;
  logic [CntW-1:0] best_first_q, best_first_d;
  logic [CntW-1:0] best_count_q, best_count_d;
  logic [CntW-1:0] position_q, position_d;
  logic            overrun_q, overrun_d;

  logic signed [ExtW-1:0] x_ext, sum, sat_ext;
  logic [SumW-1:0]        sum_sat;
  logic                   full;

  assign sat_ext = $signed({{(ExtW-SumW){1'b0}}, mst_pkg::SumSat});
  assign x_ext   = $signed({{(ExtW-SmpB){sample_i[SmpB-1]}}, sample_i[SmpB-1:0]});
  assign sum     = x_ext + $signed({{(ExtW-SumW){1'b0}}, suffix_total_q});
  assign sum_sat = (sum > sat_ext) ? mst_pkg::SumSat : sum[SumW-1:0];
  assign full    = (position_q >= CntW'(mst_pkg::MaxLen));

  always_comb begin
    suffix_total_d = suffix_total_q;
    suffix_count_d = suffix_count_q;
    best_total_d   = best_total_q;
    best_first_d   = best_first_q;
    best_count_d   = best_count_q;
    position_d     = position_q;
    overrun_d      = overrun_q;
    if (full) begin
      overrun_d = 1'b1;
    end else begin
      if (sum > $signed({{(ExtW-SumW){1'b0}}, best_total_q})) begin
        suffix_total_d = sum_sat;
        suffix_count_d = suffix_count_q + CntW'(1);
        best_total_d   = sum_sat;
        best_count_d   = suffix_count_d;
        best_first_d   = position_q + CntW'(1) - suffix_count_d;
      end else if (sum > $signed(ExtW'(0))) begin
        suffix_total_d = sum_sat;
        suffix_count_d = suffix_count_q + CntW'(1);
      end else begin
        suffix_total_d = '0;
        suffix_count_d = '0;
      end
      position_d = position_q + CntW'(1);
    end
  end

  always_comb begin
    result_o.best_sum      = best_total_d;
    result_o.best_start    = mst_pkg::FirstW'(best_first_d);
    result_o.best_length   = mst_pkg::LenW'(best_count_d);
    result_o.suffix_sum    = suffix_total_d;
    result_o.suffix_length = mst_pkg::LenW'(suffix_count_d);
    result_o.overrun       = overrun_d;
    result_o.final_res     = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suffix_total_q <= '0;
      suffix_count_q <= '0;
      best_total_q   <= '0;
      best_first_q   <= '0;
      best_count_q   <= '0;
      position_q     <= '0;
      overrun_q      <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        suffix_total_q <= '0;
        suffix_count_q <= '0;
        best_total_q   <= '0;
        best_first_q   <= '0;
        best_count_q   <= '0;
        position_q     <= '0;
        overrun_q      <= 1'b0;
      end else begin
        suffix_total_q <= suffix_total_d;
        suffix_count_q <= suffix_count_d;
        best_total_q   <= best_total_d;
        best_first_q   <= best_first_d;
        best_count_q   <= best_count_d;
        position_q     <= position_d;
        overrun_q      <= overrun_d;
      end
    end
  end

  `MST_ASSERT(a_suffix_in_seq, clk_i, rst_ni, suffix_count_q <= position_q, "suffix longer than sequence")
  `MST_ASSERT(a_best_in_seq, clk_i, rst_ni, best_count_q <= position_q, "best run longer than sequence")
  `MST_ASSERT(a_empty_best_zero, clk_i, rst_ni, (best_count_q != '0) || (best_total_q == '0), "empty best run with nonzero sum")
  `MST_ASSERT_IMP(a_last_clears, clk_i, rst_ni, step_i && last_i, (position_q == '0) && !overrun_q, "state not cleared after last")
  `MST_ASSERT_IMP(a_overrun_holds, clk_i, rst_ni, step_i && !last_i && full, $stable(position_q) && overrun_q, "overrun request changed position")
endmodule
`default_nettype wire

// ===== rtl/core/max_subarray_tracker.sv =====
// Top level of the streaming max subarray tracker with output register.
// Usage:
//   Input channel carries sample_i (signed) and last_i, handshaked by
//   in_valid_i / in_stall_o. Output channel carries one result per input
//   request, handshaked by out_valid_o / out_stall_i.
//   A request is taken when valid is high and stall is low.
//   The result is registered and shows on the outputs in the next cycle.
//   Throughput: one request per cycle when not stalled; one add and two
//   compares of the Kadane update feed the state registers in that cycle.
//   A valid result holds in the register while out_stall_i is high; in that
//   case in_stall_o rises so no result is lost. A request is still taken in the
//   cycle the held result is drained.
//   Reset (rst_ni low, async) clears the scan state and the output valid.
//   last_i ends a sequence: its result is sent and the scan state clears.
//   Past MaxLen samples, requests are ignored and overrun is flagged.
`timescale 1ns / 1ps
`default_nettype none
module max_subarray_tracker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire logic [mst_pkg::SampleW-1:0]  sample_i,
  input  wire logic                         last_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output      logic [mst_pkg::SumW-1:0]     best_sum_o,
  output      logic [mst_pkg::FirstW-1:0]   best_start_o,
  output      logic [mst_pkg::LenW-1:0]     best_length_o,
  output      logic [mst_pkg::SumW-1:0]     suffix_sum_o,
  output      logic [mst_pkg::LenW-1:0]     suffix_length_o,
  output      logic                         overrun_o,
  output      logic                         final_res_o
);
  logic                 accept;
  logic                 out_valid_q, out_valid_d;
  mst_pkg::mst_result_t step_res;
  mst_pkg::mst_result_t res_q;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  mst_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .sample_i (sample_i),
    .last_i   (last_i),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign best_sum_o      = res_q.best_sum;
  assign best_start_o    = res_q.best_start;
  assign best_length_o   = res_q.best_length;
  assign suffix_sum_o    = res_q.suffix_sum;
  assign suffix_length_o = res_q.suffix_length;
  assign overrun_o       = res_q.overrun;
  assign final_res_o     = res_q.final_res;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the max_subarray_tracker streaming Kadane scan.
`timescale 1ns / 1ps
module tb;
  import mst_pkg::*;

  typedef struct packed {
    logic [SampleW-1:0] smp;
    logic               lst;
    logic               known;
    mst_result_t        want;
  } dir_row_t;

  typedef enum int {RxFree, RxLight, RxHeavy, RxPattern} rx_mode_e;
  typedef enum int {FlavWide, FlavNarrow, FlavEdge, FlavRising} flavor_e;

  localparam int DirRows  = 19;
  localparam int ItemGoal = 1650;
  localparam int HoldLen  = 400;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [SampleW-1:0] sample_i    = '0;
  logic               last_i      = 1'b0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [SumW-1:0]    best_sum_o;
  logic [FirstW-1:0]  best_start_o;
  logic [LenW-1:0]    best_length_o;
  logic [SumW-1:0]    suffix_sum_o;
  logic [LenW-1:0]    suffix_length_o;
  logic               overrun_o;
  logic               final_res_o;

  max_subarray_tracker u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_i,
    .last_i,
    .out_valid_o,
    .out_stall_i,
    .best_sum_o,
    .best_start_o,
    .best_length_o,
    .suffix_sum_o,
    .suffix_length_o,
    .overrun_o,
    .final_res_o
  );

  always #2 clk_i = ~clk_i;

  // scan state mirrored from the block
  longint sfx_total = 0;
  int     sfx_count = 0;
  longint top_total = 0;
  int     top_first = 0;
  int     top_count = 0;
  int     seq_pos   = 0;
  bit     ovr_seen  = 1'b0;

  mst_result_t scan_results_q[$];
  dir_row_t    dir_table [DirRows];
  int          n_sent     = 0;
  int          bad_fields = 0;
  int          burst_left = 0;
  bit          steady     = 1'b1;
  bit          hold_req   = 1'b0;

  function automatic longint clip_sum(longint s);
    return (s > longint'(SumSat)) ? longint'(SumSat) : s;
  endfunction

  function automatic mst_result_t kadane_step(logic [SampleW-1:0] raw, logic fin);
    mst_result_t r;
    longint      x;
    longint      s;
    x = longint'($signed(raw));
    if (seq_pos >= MaxLen) begin
      ovr_seen = 1'b1;
    end else begin
      s = x + sfx_total;
      if (s > top_total) begin
        sfx_total = clip_sum(s);
        sfx_count++;
        top_total = sfx_total;
        top_count = sfx_count;
        top_first = seq_pos + 1 - sfx_count;
      end else if (s > 0) begin
        sfx_total = clip_sum(s);
        sfx_count++;
      end else begin
        sfx_total = 0;
        sfx_count = 0;
      end
      seq_pos++;
    end
    r.best_sum      = top_total[SumW-1:0];
    r.best_start    = top_first[FirstW-1:0];
    r.best_length   = top_count[LenW-1:0];
    r.suffix_sum    = sfx_total[SumW-1:0];
    r.suffix_length = sfx_count[LenW-1:0];
    r.overrun       = ovr_seen;
    r.final_res     = fin;
    if (fin) begin
      sfx_total = 0;
      sfx_count = 0;
      top_total = 0;
      top_first = 0;
      top_count = 0;
      seq_pos   = 0;
      ovr_seen  = 1'b0;
    end
    return r;
  endfunction

  function automatic mst_result_t pack_scan(int bs, int st, int bl, int ss, int sl,
                                            bit ov, bit fr);
    mst_result_t r;
    r.best_sum      = bs[SumW-1:0];
    r.best_start    = st[FirstW-1:0];
    r.best_length   = bl[LenW-1:0];
    r.suffix_sum    = ss[SumW-1:0];
    r.suffix_length = sl[LenW-1:0];
    r.overrun       = ov;
    r.final_res     = fr;
    return r;
  endfunction

  function automatic logic [SampleW-1:0] pick_sample(flavor_e flav);
    logic [SampleW-1:0] v;
    case (flav)
      FlavWide:   v = SampleW'($urandom_range(0, 65535));
      FlavNarrow: v = SampleW'($urandom_range(0, 16)) - SampleW'(8);
      FlavEdge: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          3:       v = 16'hFFFF;
          default: v = 16'h0001;
        endcase
      end
      default: begin
        if ($urandom_range(0, 3) == 0) v = SampleW'(0 - int'($urandom_range(0, 32768)));
        else v = SampleW'($urandom_range(0, 32767));
      end
    endcase
    return v;
  endfunction

  // one request; returns at the falling edge after it was taken, gaps included
  task automatic offer(input logic [SampleW-1:0] smp, input logic lst,
                       input bit known, input mst_result_t want);
    mst_result_t pred;
    int          gap;
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    last_i     <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = kadane_step(smp, lst);
    scan_results_q.push_back(known ? want : pred);
    n_sent++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = steady ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(0, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (scan_results_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cmp(input string fld, input logic [31:0] w, input logic [31:0] g);
    if (w !== g) begin
      bad_fields++;
      if (bad_fields <= 10)
        $display("%0t mismatch %s: expected %0d got %0d", $realtime, fld, w, g);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    mst_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (scan_results_q.size() == 0) begin
        bad_fields++;
        if (bad_fields <= 10) $display("%0t result with none pending", $realtime);
      end else begin
        want = scan_results_q.pop_front();
        cmp("best_sum", 32'(want.best_sum), 32'(best_sum_o));
        cmp("best_start", 32'(want.best_start), 32'(best_start_o));
        cmp("best_length", 32'(want.best_length), 32'(best_length_o));
        cmp("suffix_sum", 32'(want.suffix_sum), 32'(suffix_sum_o));
        cmp("suffix_length", 32'(want.suffix_length), 32'(suffix_length_o));
        cmp("overrun", 32'(want.overrun), 32'(overrun_o));
        cmp("final_res", 32'(want.final_res), 32'(final_res_o));
      end
    end
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin : rx_side
    rx_mode_e mode;
    int       left;
    int       tick;
    mode = RxFree;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldLen) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end else begin
          left--;
        end
        case (mode)
          RxFree:  out_stall_i <= 1'b0;
          RxLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          RxHeavy: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  initial begin : stim
    int          seq_no;
    int          len;
    flavor_e     flav;
    mst_result_t none;
    none = '0;
    dir_table = '{
      '{16'h7FFF, 1'b0, 1'b1, pack_scan(32767, 0, 1, 32767, 1, 0, 0)},
      '{16'h8000, 1'b1, 1'b1, pack_scan(32767, 0, 1, 0, 0, 0, 1)},
      '{16'h0000, 1'b1, 1'b1, pack_scan(0, 0, 0, 0, 0, 0, 1)},
      '{16'hFFFF, 1'b0, 1'b1, pack_scan(0, 0, 0, 0, 0, 0, 0)},
      '{16'h0005, 1'b0, 1'b0, none},
      '{16'hFFFB, 1'b0, 1'b0, none},  // suffix sums to exactly zero
      '{16'h0005, 1'b0, 1'b0, none},  // ties the best, must not replace it
      '{16'h0001, 1'b0, 1'b0, none},
      '{16'hFFF9, 1'b0, 1'b0, none},
      '{16'h7FFF, 1'b0, 1'b0, none},
      '{16'h7FFF, 1'b0, 1'b0, none},
      '{16'h8000, 1'b0, 1'b0, none},
      '{16'h8000, 1'b1, 1'b0, none},
      '{16'h8000, 1'b0, 1'b1, pack_scan(0, 0, 0, 0, 0, 0, 0)},
      '{16'h8000, 1'b1, 1'b1, pack_scan(0, 0, 0, 0, 0, 0, 1)},
      '{16'h5555, 1'b0, 1'b0, none},
      '{16'hAAAA, 1'b0, 1'b0, none},
      '{16'h0001, 1'b0, 1'b0, none},
      '{16'h0000, 1'b1, 1'b0, none}
    };
    seq_no = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    steady = 1'b1;
    foreach (dir_table[i])
      offer(dir_table[i].smp, dir_table[i].lst, dir_table[i].known, dir_table[i].want);
    wait_drained();

    while (n_sent < ItemGoal) begin
      seq_no++;
      steady = ($urandom_range(0, 3) == 0);
      if (seq_no == 15) begin
        // runs past MaxLen; last lands on an ignored sample
        steady   = 1'b1;
        hold_req = 1'b1;
        len = MaxLen + $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          offer(pick_sample(FlavRising), k == len - 1, 1'b0, none);
      end else begin
        if (seq_no == 40) begin
          steady   = 1'b1;
          hold_req = 1'b1;
        end
        flav = flavor_e'($urandom_range(0, 3));
        len  = $urandom_range(1, 24);
        for (int k = 0; k < len; k++)
          offer(pick_sample(flav), k == len - 1, 1'b0, none);
      end
      if (seq_no == 25 || $urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (bad_fields == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
